// ===== rtl/pt64_pkg.sv =====
// ----------------------------------------------------------------------------
// pt64_pkg
// shared types and constants for the 64-bit primality tester
// ----------------------------------------------------------------------------
package pt64_pkg;

    localparam int TRIAL_LIMIT_DEFAULT   = 100;
    localparam int WITNESS_COUNT_DEFAULT = 12;
    localparam int VALUE_WIDTH_DEFAULT   = 64;

    localparam int BASE_COUNT = 12;
    localparam int BASE_IDX_W = 4;
    localparam int BASE_W     = 6;

    localparam logic [BASE_W-1:0] WITNESS_BASES [BASE_COUNT] =
        '{6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIAL_CHK,
        ST_TRIAL_DIV,
        ST_MR_START,
        ST_MR_RED,
        ST_MR_SPLIT,
        ST_POW_CHK,
        ST_POW_MUL,
        ST_POW_SQ,
        ST_MR_CHK0,
        ST_SQ_CHK,
        ST_SQ_WAIT,
        ST_NEXT_W,
        ST_FINISH
    } pt64_state_t;

endpackage

// ===== rtl/pt64_modmul.sv =====
// ----------------------------------------------------------------------------
// pt64_modmul
// bit-serial modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module pt64_modmul
    import pt64_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] op_a,
    input  logic [VALUE_WIDTH-1:0] op_b,
    input  logic [VALUE_WIDTH-1:0] modulus,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] product
);

    localparam int BW = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] a_reg;
    logic [VALUE_WIDTH-1:0] b_reg;
    logic [VALUE_WIDTH-1:0] m_reg;
    logic [BW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [VALUE_WIDTH-1:0] dbl;

    function automatic logic [VALUE_WIDTH-1:0] add_mod(
        input logic [VALUE_WIDTH-1:0] x,
        input logic [VALUE_WIDTH-1:0] y,
        input logic [VALUE_WIDTH-1:0] m
    );
        logic [VALUE_WIDTH-1:0] gap;
        gap = m - y;
        add_mod = (x >= gap) ? (x - gap) : (x + y);
    endfunction

    always_comb
    begin
        dbl      = add_mod(acc_reg, acc_reg, m_reg);
        acc_next = b_reg[VALUE_WIDTH-1] ? add_mod(dbl, a_reg, m_reg) : dbl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= BW'(VALUE_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
            m_reg   <= modulus;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/primality_test_64bit.sv =====
// ----------------------------------------------------------------------------
// primality_test_64bit
// deterministic primality test: trial division, then twelve-base miller-rabin
// ----------------------------------------------------------------------------
// miller-rabin run time is set by the bit-serial modular multiplier
// (one multiplier bit per cycle, one product at a time)
// throughput: one item at a time; a new transfer is taken once the prior ends
// reset: asynchronous active low, clears the sequencer and output valid
// ----------------------------------------------------------------------------
module primality_test_64bit
    import pt64_pkg::*;
#(
    parameter int TRIAL_LIMIT   = TRIAL_LIMIT_DEFAULT,
    parameter int WITNESS_COUNT = WITNESS_COUNT_DEFAULT,
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] candidate,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [VALUE_WIDTH-1:0] tested_value,
    output logic                   prime_flag
);

    localparam int PW = $clog2(TRIAL_LIMIT + 1);
    localparam int BW = $clog2(VALUE_WIDTH);
    localparam int CW = (2 * PW > VALUE_WIDTH) ? 2 * PW : VALUE_WIDTH;

    pt64_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [PW-1:0]          p_reg, p_next;
    logic [PW-1:0]          r_reg, r_next;
    logic [BW-1:0]          bit_reg, bit_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [BW-1:0]          twos_reg, twos_next;
    logic [BW-1:0]          i_reg, i_next;
    logic [BASE_IDX_W-1:0]  w_reg, w_next;
    logic                   flag_reg, flag_next;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_flag_reg;

    logic                   in_xfer;
    logic                   out_free;
    logic [2*PW-1:0]        p_sq;
    logic                   sq_above;
    logic [PW:0]            r_shift;
    logic [PW-1:0]          r_mod;
    logic [VALUE_WIDTH-1:0] n_minus_one;
    logic                   last_w;

    logic                   mul_start;
    logic [VALUE_WIDTH-1:0] mul_a;
    logic [VALUE_WIDTH-1:0] mul_b;
    logic                   mul_done;
    logic [VALUE_WIDTH-1:0] mul_prod;

    pt64_modmul #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (n_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign p_sq        = {{PW{1'b0}}, p_reg} * {{PW{1'b0}}, p_reg};
    assign sq_above    = CW'(p_sq) > CW'(n_reg);
    assign r_shift     = {r_reg, n_reg[bit_reg]};
    assign r_mod       = (r_shift >= {1'b0, p_reg}) ? PW'(r_shift - {1'b0, p_reg})
                                                    : PW'(r_shift);
    assign n_minus_one = n_reg - 1'b1;
    assign last_w      = (w_reg == BASE_IDX_W'(WITNESS_COUNT - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (candidate < VALUE_WIDTH'(2)) ? ST_FINISH : ST_TRIAL_CHK;
                end
            end
            ST_TRIAL_CHK:
            begin
                if (p_reg == PW'(TRIAL_LIMIT))
                begin
                    state_next = ST_MR_START;
                end
                else if (sq_above)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_TRIAL_DIV;
                end
            end
            ST_TRIAL_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = (r_mod == '0) ? ST_FINISH : ST_TRIAL_CHK;
                end
            end
            ST_MR_START: state_next = ST_MR_RED;
            ST_MR_RED:
            begin
                if (b_reg < n_reg)
                begin
                    state_next = (b_reg == '0) ? ST_NEXT_W : ST_MR_SPLIT;
                end
            end
            ST_MR_SPLIT:
            begin
                if (d_reg[0])
                begin
                    state_next = ST_POW_CHK;
                end
            end
            ST_POW_CHK:
            begin
                if (d_reg == '0)
                begin
                    state_next = ST_MR_CHK0;
                end
                else
                begin
                    state_next = d_reg[0] ? ST_POW_MUL : ST_POW_SQ;
                end
            end
            ST_POW_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_POW_SQ;
                end
            end
            ST_POW_SQ:
            begin
                if (mul_done)
                begin
                    state_next = ST_POW_CHK;
                end
            end
            ST_MR_CHK0:
            begin
                if (acc_reg == VALUE_WIDTH'(1) || acc_reg == n_minus_one)
                begin
                    state_next = ST_NEXT_W;
                end
                else
                begin
                    state_next = ST_SQ_CHK;
                end
            end
            ST_SQ_CHK:
            begin
                state_next = (i_reg < twos_reg) ? ST_SQ_WAIT : ST_FINISH;
            end
            ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (mul_prod == n_minus_one) ? ST_NEXT_W : ST_SQ_CHK;
                end
            end
            ST_NEXT_W:   state_next = last_w ? ST_FINISH : ST_MR_START;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and multiplier control
    always_comb
    begin
        n_next    = n_reg;
        p_next    = p_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        acc_next  = acc_reg;
        twos_next = twos_reg;
        i_next    = i_reg;
        w_next    = w_reg;
        flag_next = flag_reg;
        mul_start = 1'b0;
        mul_a     = acc_reg;
        mul_b     = b_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next    = candidate;
                    p_next    = PW'(2);
                    flag_next = 1'b0;
                end
            end
            ST_TRIAL_CHK:
            begin
                r_next    = '0;
                bit_next  = BW'(VALUE_WIDTH - 1);
                w_next    = '0;
                flag_next = sq_above;
            end
            ST_TRIAL_DIV:
            begin
                r_next   = r_mod;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    p_next    = p_reg + 1'b1;
                    flag_next = (CW'(n_reg) == CW'(p_reg));
                end
            end
            ST_MR_START:
            begin
                b_next = VALUE_WIDTH'(WITNESS_BASES[w_reg]);
            end
            ST_MR_RED:
            begin
                if (b_reg >= n_reg)
                begin
                    b_next = b_reg - n_reg;
                end
                d_next    = n_minus_one;
                twos_next = '0;
            end
            ST_MR_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_next    = {1'b0, d_reg[VALUE_WIDTH-1:1]};
                    twos_next = twos_reg + 1'b1;
                end
                acc_next = VALUE_WIDTH'(1);
            end
            ST_POW_CHK:
            begin
                if (d_reg != '0)
                begin
                    mul_start = 1'b1;
                    mul_a     = d_reg[0] ? acc_reg : b_reg;
                end
                i_next = BW'(1);
            end
            ST_POW_MUL:
            begin
                if (mul_done)
                begin
                    acc_next  = mul_prod;
                    mul_start = 1'b1;
                    mul_a     = b_reg;
                end
            end
            ST_POW_SQ:
            begin
                if (mul_done)
                begin
                    b_next = mul_prod;
                    d_next = {1'b0, d_reg[VALUE_WIDTH-1:1]};
                end
            end
            ST_SQ_CHK:
            begin
                if (i_reg < twos_reg)
                begin
                    mul_start = 1'b1;
                    mul_b     = acc_reg;
                end
                flag_next = 1'b0;
            end
            ST_SQ_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next = mul_prod;
                    i_next   = i_reg + 1'b1;
                end
            end
            ST_NEXT_W:
            begin
                w_next    = w_reg + 1'b1;
                flag_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        p_reg    <= p_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        acc_reg  <= acc_next;
        twos_reg <= twos_next;
        i_reg    <= i_next;
        w_reg    <= w_next;
        flag_reg <= flag_next;
        if (state_reg == ST_FINISH && out_free)
        begin
            out_value_reg <= n_reg;
            out_flag_reg  <= flag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tested_value = out_value_reg;
    assign prime_flag   = out_flag_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for primality_test_64bit: directed table of edge numbers,
// then random candidates, checked against the table flag where known, else a 128-bit
// miller-rabin predictor, with random idling on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module testbench;
    import pt64_pkg::*;

    localparam int VW          = VALUE_WIDTH_DEFAULT;
    localparam int WATCH_LIMIT = 400000;

    typedef struct {
        logic [VW-1:0] value;
        bit            known;
        bit            flag;
    } stim_row_t;

    typedef struct {
        logic [VW-1:0] value;
        bit            flag;
    } verdict_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [VW-1:0] candidate = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [VW-1:0] tested_value;
    logic          prime_flag;

    verdict_t      pending_verdicts[$];
    int            mismatches = 0;
    int            results_seen = 0;
    int            primes_seen = 0;
    int            idle_cycles = 0;
    bit            quiet = 1'b0;

    primality_test_64bit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .candidate    (candidate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tested_value (tested_value),
        .prime_flag   (prime_flag)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [VW-1:0] mul_mod(logic [VW-1:0] a, logic [VW-1:0] b,
                                              logic [VW-1:0] m);
        logic [2*VW-1:0] prod;
        prod = {{VW{1'b0}}, a} * {{VW{1'b0}}, b};
        return VW'(prod % {{VW{1'b0}}, m});
    endfunction

    function automatic logic [VW-1:0] pow_mod(logic [VW-1:0] b, logic [VW-1:0] e,
                                              logic [VW-1:0] m);
        logic [VW-1:0] acc;
        acc = 1;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod(acc, b, m);
            b = mul_mod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit strong_witness_passes(logic [VW-1:0] n, logic [VW-1:0] base);
        logic [VW-1:0] d;
        logic [VW-1:0] x;
        int            twos;
        d = n - 1;
        twos = 0;
        if (base % n == 0)
            return 1'b1;
        while (!d[0])
        begin
            d = d >> 1;
            twos++;
        end
        x = pow_mod(base, d, n);
        if (x == 1 || x == n - 1)
            return 1'b1;
        for (int i = 1; i < twos; i++)
        begin
            x = mul_mod(x, x, n);
            if (x == n - 1)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit predict_prime(logic [VW-1:0] n);
        if (n < 2)
            return 1'b0;
        for (int p = 2; p < TRIAL_LIMIT_DEFAULT; p++)
        begin
            if (VW'(p * p) > n)
                return 1'b1;
            if (n % p == 0)
                return n == p;
        end
        for (int w = 0; w < WITNESS_COUNT_DEFAULT; w++)
            if (!strong_witness_passes(n, VW'(WITNESS_BASES[w])))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        mismatches++;
    endtask

    // sends one candidate, idling at random first; pushes the expectation on transfer
    task automatic send_candidate(logic [VW-1:0] v, bit known, bit flag);
        verdict_t exp_v;
        while (!quiet && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= v;
        do
            @(posedge clk);
        while (in_stall);
        exp_v.value = v;
        exp_v.flag  = known ? flag : predict_prime(v);
        if (known && flag != predict_prime(v))
            $display("note: table entry %0d disagrees with predictor", v);
        pending_verdicts.push_back(exp_v);
    endtask

    function automatic logic [VW-1:0] rand_wide();
        return {$urandom(), $urandom()};
    endfunction

    stim_row_t directed[19] = '{
        '{64'd0, 1, 0},
        '{64'd1, 1, 0},
        '{64'd2, 1, 1},
        '{64'd3, 1, 1},
        '{64'd4, 1, 0},
        '{64'd97, 1, 1},
        '{64'd99, 1, 0},
        '{64'd561, 1, 0},
        '{64'd9801, 1, 0},
        '{64'd9973, 0, 0},
        '{64'd10007, 0, 0},
        '{64'd10201, 0, 0},
        '{64'd3215031751, 0, 0},
        '{64'd4294967311, 0, 0},
        '{64'h7FFF_FFFF_FFFF_FFE7, 0, 0},
        '{64'h8000_0000_0000_0000, 1, 0},
        '{64'hFFFF_FFFF_FFFF_FFC5, 1, 1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1, 0},
        '{64'hFFFF_FFFF_FFFF_FFFE, 1, 0}
    };

    initial
    begin
        logic [VW-1:0] v;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_candidate(directed[i].value, directed[i].known, directed[i].flag);
        for (int k = 0; k < 100; k++)
        begin
            quiet = (k >= 40 && k < 55);
            case ($urandom_range(9))
                0, 1, 2, 3: v = VW'($urandom_range(20000));
                4, 5, 6:    v = rand_wide() | 1;
                7:          v = VW'($urandom_range(65535)) * VW'($urandom_range(65535) | 1);
                default:    v = rand_wide();
            endcase
            send_candidate(v, 1'b0, 1'b0);
        end
        quiet = 1'b0;
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("run covered %0d results, %0d prime, directed edge values and random",
                 results_seen, primes_seen);
        $display("candidates across small, odd 64-bit and product ranges");
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // output stall: random, one long hold-off while the sender keeps offering
    initial
    begin
        @(posedge rst_n);
        repeat (3000)
        begin
            out_stall <= !quiet && ($urandom_range(99) < 26);
            @(posedge clk);
        end
        out_stall <= 1'b1;
        repeat (20000) @(posedge clk);
        forever
        begin
            out_stall <= !quiet && ($urandom_range(99) < 26);
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch("unexpected transfer", tested_value, '0);
            end
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (tested_value !== exp_v.value)
                    report_mismatch("tested_value", tested_value, exp_v.value);
                if (prime_flag !== exp_v.flag)
                    report_mismatch("prime_flag", VW'(prime_flag), VW'(exp_v.flag));
                if (exp_v.flag)
                    primes_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_verdicts.size());
            $display("FAILURE");
            $finish;
        end
    end

endmodule
